@@ src/rc_frame_receiver_core_defines.svh @@
// Assertion macros for the radio-control frame receiver.
// Used by rc_frame_receiver_core; expects a clock named clk and a reset named rst.
`ifndef RC_FRAME_RECEIVER_CORE_DEFINES_SVH
`define RC_FRAME_RECEIVER_CORE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define RCFR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rc frame receiver: implication check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define RCFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rc frame receiver: next-cycle check failed");

`endif

@@ src/rcfr_pkg.sv @@
// Shared types and constants for the radio-control frame receiver.
// No dependencies; imported by rc_frame_receiver_core.
package rcfr_pkg;

  localparam int MAX_CHANNELS   = 256;
  localparam int MAX_VALUE_BITS = 12;
  localparam int FIFO_DEPTH     = 4;
  localparam int PTR_W          = $clog2(FIFO_DEPTH);
  localparam int CNT_W          = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] START_MARKER_RESET = 8'd201;
  localparam logic [7:0] END_MARKER_RESET   = 8'd147;
  localparam logic [7:0] ERROR_STEP         = 8'd4;

  localparam logic [7:0] REG_START_MARKER = 8'd0;
  localparam logic [7:0] REG_END_MARKER   = 8'd1;

  localparam logic KIND_CHANNEL = 1'b0;
  localparam logic KIND_FRAME   = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_PID  = 3'd1,
    PH_TID  = 3'd2,
    PH_CFG  = 3'd3,
    PH_MESH = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6,
    PH_END  = 3'd7
  } phase_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  channel_index;
    logic [11:0] channel_value;
    logic [7:0]  packet_id;
    logic [7:0]  transmitter_id;
    logic [3:0]  route_len;
    logic        checksum_ok;
    logic        end_ok;
    logic [7:0]  error_count;
    logic        last;
  } result_t;

endpackage

@@ src/rc_frame_receiver_core.sv @@
// Radio-control frame receiver: one received byte per transaction in, channel
// values and frame status out. Each byte is parsed combinationally from the
// frame registers into a four-entry result queue. A byte is taken every cycle
// while the queue has room for two results; a byte that completes two channel
// values pushes two results; the sustained rate is one byte per cycle except
// where the output side (one result per unstalled cycle) is the limit. Channel
// values of a failed frame are still delivered; the frame result that follows
// the end byte reports checksum_ok and end_ok. The markers are written through
// the configuration port (index 0 start marker, index 1 end marker).
`include "rc_frame_receiver_core_defines.svh"

module rc_frame_receiver_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        kind,
  output logic [7:0]  channel_index,
  output logic [11:0] channel_value,
  output logic [7:0]  packet_id,
  output logic [7:0]  transmitter_id,
  output logic [3:0]  route_len,
  output logic        checksum_ok,
  output logic        end_ok,
  output logic [7:0]  error_count,
  output logic        last
);
  import rcfr_pkg::*;

  logic [7:0]  start_marker;
  logic [7:0]  end_marker;

  phase_t      phase, phase_next;
  logic [7:0]  frame_packet_id, frame_packet_id_next;
  logic [7:0]  frame_transmitter_id, frame_transmitter_id_next;
  logic [3:0]  bits_per_channel, bits_per_channel_next;
  logic [8:0]  channels_in_frame, channels_in_frame_next;
  logic [8:0]  data_bytes_left, data_bytes_left_next;
  logic [11:0] channel_accumulator, channel_accumulator_next;
  logic [8:0]  channel_counter, channel_counter_next;
  logic [3:0]  bit_position, bit_position_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [3:0]  frame_routing, frame_routing_next;
  logic        checksum_matched, checksum_matched_next;
  logic [7:0]  error_counter, error_counter_next;

  result_t     fifo [FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  logic        rx_acc;
  logic        res_acc;
  logic [1:0]  push_n;
  result_t     res0, res1;

  logic [3:0]  cfg_bits;
  logic [2:0]  cfg_ckey;
  logic [8:0]  cfg_chans;
  logic [12:0] cfg_total;

  logic [11:0] v0, v1;
  logic [8:0]  i0, i1;
  logic [1:0]  n_chan;
  logic [11:0] acc;
  logic [3:0]  pos;
  logic [8:0]  cnt;
  logic [8:0]  left_dec;

  assign cfg_ready = 1'b1;
  assign rx_acc    = rx_valid && !rx_stall;
  assign res_acc   = res_valid && !res_stall;

  // Channel-count key and data length from the configuration byte.
  always_comb begin
    cfg_bits = 4'd5 + {1'b0, rx_byte[2:0]};
    if (cfg_bits > 4'(MAX_VALUE_BITS)) begin
      cfg_bits = 4'(MAX_VALUE_BITS);
    end
    cfg_ckey  = rx_byte[5:3];
    cfg_chans = (cfg_ckey == 3'd7) ? 9'd256 : (9'd1 << cfg_ckey);
    if (cfg_chans > 9'(MAX_CHANNELS)) begin
      cfg_chans = 9'(MAX_CHANNELS);
    end
    cfg_total = 13'(cfg_bits) * 13'(cfg_chans) + 13'd7;
  end

  // Unpack the eight bits of one data byte, LSB first.
  always_comb begin
    acc    = channel_accumulator;
    pos    = bit_position;
    cnt    = channel_counter;
    n_chan = 2'd0;
    v0     = '0;
    v1     = '0;
    i0     = '0;
    i1     = '0;
    for (int i = 0; i < 8; i++) begin
      if (cnt < channels_in_frame) begin
        if (rx_byte[i]) begin
          acc[pos] = 1'b1;
        end
        pos = pos + 4'd1;
        if (pos >= bits_per_channel) begin
          if (n_chan == 2'd0) begin
            v0 = acc;
            i0 = cnt;
          end else begin
            v1 = acc;
            i1 = cnt;
          end
          n_chan = n_chan + 2'd1;
          cnt    = cnt + 9'd1;
          acc    = '0;
          pos    = '0;
        end
      end
    end
    left_dec = (data_bytes_left != '0) ? data_bytes_left - 9'd1 : data_bytes_left;
  end

  // Next state.
  always_comb begin
    phase_next                = phase;
    frame_packet_id_next      = frame_packet_id;
    frame_transmitter_id_next = frame_transmitter_id;
    bits_per_channel_next     = bits_per_channel;
    channels_in_frame_next    = channels_in_frame;
    data_bytes_left_next      = data_bytes_left;
    channel_accumulator_next  = channel_accumulator;
    channel_counter_next      = channel_counter;
    bit_position_next         = bit_position;
    running_xor_next          = running_xor;
    frame_routing_next        = frame_routing;
    checksum_matched_next     = checksum_matched;
    error_counter_next        = error_counter;
    unique case (phase)
      PH_IDLE: begin
        if (rx_byte == start_marker) begin
          running_xor_next      = '0;
          frame_routing_next    = '0;
          checksum_matched_next = 1'b0;
          phase_next            = PH_PID;
        end
      end
      PH_PID: begin
        frame_packet_id_next = rx_byte;
        running_xor_next     = rx_byte;
        phase_next           = PH_TID;
      end
      PH_TID: begin
        frame_transmitter_id_next = rx_byte;
        running_xor_next          = running_xor ^ rx_byte;
        phase_next                = PH_CFG;
      end
      PH_CFG: begin
        bits_per_channel_next    = cfg_bits;
        channels_in_frame_next   = cfg_chans;
        data_bytes_left_next     = cfg_total[11:3];
        channel_accumulator_next = '0;
        channel_counter_next     = '0;
        bit_position_next        = '0;
        running_xor_next         = running_xor ^ rx_byte;
        phase_next               = rx_byte[7] ? PH_MESH : PH_DATA;
      end
      PH_MESH: begin
        frame_routing_next = rx_byte[3:0];
        running_xor_next   = running_xor ^ rx_byte;
        phase_next         = PH_DATA;
      end
      PH_DATA: begin
        running_xor_next         = running_xor ^ rx_byte;
        channel_accumulator_next = acc;
        bit_position_next        = pos;
        channel_counter_next     = cnt;
        data_bytes_left_next     = left_dec;
        if (left_dec == '0) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        checksum_matched_next = (rx_byte == running_xor);
        if (rx_byte != running_xor) begin
          error_counter_next = error_counter + ERROR_STEP;
        end
        phase_next = PH_END;
      end
      PH_END: begin
        if (rx_byte != end_marker) begin
          error_counter_next = error_counter + ERROR_STEP;
        end
        phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // Results produced by the current byte.
  always_comb begin
    res0 = '0;
    res0.packet_id      = frame_packet_id;
    res0.transmitter_id = frame_transmitter_id;
    res0.route_len      = frame_routing;
    res0.error_count    = error_counter_next;
    res1 = res0;
    push_n = 2'd0;
    if (rx_acc) begin
      if (phase == PH_DATA) begin
        push_n              = n_chan;
        res0.kind           = KIND_CHANNEL;
        res0.channel_index  = i0[7:0];
        res0.channel_value  = v0;
        res0.last           = (n_chan == 2'd1);
        res1.kind           = KIND_CHANNEL;
        res1.channel_index  = i1[7:0];
        res1.channel_value  = v1;
        res1.last           = 1'b1;
      end else if (phase == PH_END) begin
        push_n           = 2'd1;
        res0.kind        = KIND_FRAME;
        res0.checksum_ok = checksum_matched;
        res0.end_ok      = (rx_byte == end_marker);
        res0.last        = 1'b1;
      end
    end
  end

  // Outputs.
  always_comb begin
    rx_stall       = (count > CNT_W'(FIFO_DEPTH - 2));
    res_valid      = (count != '0);
    kind           = fifo[head].kind;
    channel_index  = fifo[head].channel_index;
    channel_value  = fifo[head].channel_value;
    packet_id      = fifo[head].packet_id;
    transmitter_id = fifo[head].transmitter_id;
    route_len      = fifo[head].route_len;
    checksum_ok    = fifo[head].checksum_ok;
    end_ok         = fifo[head].end_ok;
    error_count    = fifo[head].error_count;
    last           = fifo[head].last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_START_MARKER) begin
        start_marker <= cfg_data;
      end else if (cfg_index == REG_END_MARKER) begin
        end_marker <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_IDLE;
      frame_packet_id      <= '0;
      frame_transmitter_id <= '0;
      bits_per_channel     <= 4'(MAX_VALUE_BITS);
      channels_in_frame    <= '0;
      data_bytes_left      <= '0;
      channel_accumulator  <= '0;
      channel_counter      <= '0;
      bit_position         <= '0;
      running_xor          <= '0;
      frame_routing        <= '0;
      checksum_matched     <= 1'b0;
      error_counter        <= '0;
    end else if (rx_acc) begin
      phase                <= phase_next;
      frame_packet_id      <= frame_packet_id_next;
      frame_transmitter_id <= frame_transmitter_id_next;
      bits_per_channel     <= bits_per_channel_next;
      channels_in_frame    <= channels_in_frame_next;
      data_bytes_left      <= data_bytes_left_next;
      channel_accumulator  <= channel_accumulator_next;
      channel_counter      <= channel_counter_next;
      bit_position         <= bit_position_next;
      running_xor          <= running_xor_next;
      frame_routing        <= frame_routing_next;
      checksum_matched     <= checksum_matched_next;
      error_counter        <= error_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo[tail] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo[tail + PTR_W'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_W'(push_n);
      head  <= head + PTR_W'(res_acc);
      count <= count + CNT_W'(push_n) - CNT_W'(res_acc);
    end
  end

  `RCFR_ASSERT_IMPLY(a_fifo_bound, 1'b1, count <= CNT_W'(FIFO_DEPTH))
  `RCFR_ASSERT_IMPLY(a_idle_silent, rx_acc && phase == PH_IDLE, push_n == 2'd0)
  `RCFR_ASSERT_IMPLY(a_end_one_frame, rx_acc && phase == PH_END,
                     push_n == 2'd1 && res0.kind == KIND_FRAME)
  `RCFR_ASSERT_NEXT(a_end_to_idle, rx_acc && phase == PH_END, phase == PH_IDLE)

endmodule

@@ tb/rc_frame_receiver_core_test.sv @@
// Self-checking testbench for rc_frame_receiver_core: byte stream in, channel and
// frame results out. Depends on rcfr_pkg and the core RTL; a scoreboard class tracks
// the frame parser and holds the results still due.
`timescale 1ns / 1ps

module rc_frame_receiver_core_test;
  import rcfr_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 10;

  class frame_scoreboard;
    logic [7:0]  start_mark, end_mark;
    phase_t      ph;
    logic [7:0]  pid, tid, xsum, errs;
    logic [3:0]  bits, bit_pos, route;
    logic [8:0]  chans, bytes_left, chan_cnt;
    logic [11:0] acc;
    logic        sum_ok;
    result_t     pending_results[$];
    int unsigned faults;

    function new();
      start_mark = START_MARKER_RESET;
      end_mark   = END_MARKER_RESET;
      ph         = PH_IDLE;
      pid        = '0;
      tid        = '0;
      xsum       = '0;
      errs       = '0;
      bits       = 4'd12;
      bit_pos    = '0;
      route      = '0;
      chans      = '0;
      bytes_left = '0;
      chan_cnt   = '0;
      acc        = '0;
      sum_ok     = 1'b0;
      faults     = 0;
    endfunction

    function void set_markers(logic [7:0] s, logic [7:0] e);
      start_mark = s;
      end_mark   = e;
    endfunction

    function result_t make_result(logic k, logic [7:0] idx, logic [11:0] val,
                                  logic cok, logic eok);
      result_t r;
      r.kind           = k;
      r.channel_index  = idx;
      r.channel_value  = val;
      r.packet_id      = pid;
      r.transmitter_id = tid;
      r.route_len      = route;
      r.checksum_ok    = cok;
      r.end_ok         = eok;
      r.error_count    = errs;
      r.last           = 1'b0;
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      result_t     out[$];
      int unsigned n_bits, n_chans;
      logic [2:0]  ckey;
      logic        eok;
      case (ph)
        PH_IDLE: begin
          if (b == start_mark) begin
            xsum   = '0;
            route  = '0;
            sum_ok = 1'b0;
            ph     = PH_PID;
          end
        end
        PH_PID: begin
          pid  = b;
          xsum = b;
          ph   = PH_TID;
        end
        PH_TID: begin
          tid  = b;
          xsum ^= b;
          ph   = PH_CFG;
        end
        PH_CFG: begin
          n_bits = 5 + b[2:0];
          if (n_bits > MAX_VALUE_BITS) n_bits = MAX_VALUE_BITS;
          ckey = b[5:3];
          n_chans = (ckey == 3'd7) ? 256 : (1 << ckey);
          if (n_chans > MAX_CHANNELS) n_chans = MAX_CHANNELS;
          bits       = 4'(n_bits);
          chans      = 9'(n_chans);
          bytes_left = 9'((n_bits * n_chans + 7) / 8);
          acc        = '0;
          chan_cnt   = '0;
          bit_pos    = '0;
          xsum ^= b;
          ph = b[7] ? PH_MESH : PH_DATA;
        end
        PH_MESH: begin
          route = b[3:0];
          xsum ^= b;
          ph    = PH_DATA;
        end
        PH_DATA: begin
          xsum ^= b;
          for (int i = 0; i < 8; i++) begin
            if (chan_cnt >= chans) break;
            if (b[i]) acc[bit_pos] = 1'b1;
            bit_pos++;
            if (bit_pos >= bits) begin
              if (out.size() < 2)
                out.push_back(make_result(KIND_CHANNEL, chan_cnt[7:0], acc, 1'b0, 1'b0));
              chan_cnt++;
              acc     = '0;
              bit_pos = '0;
            end
          end
          if (bytes_left > 0) bytes_left--;
          if (bytes_left == 0) ph = PH_SUM;
        end
        PH_SUM: begin
          sum_ok = (b == xsum);
          if (!sum_ok) errs += ERROR_STEP;
          ph = PH_END;
        end
        default: begin
          eok = (b == end_mark);
          if (!eok) errs += ERROR_STEP;
          out.push_back(make_result(KIND_FRAME, 8'd0, 12'd0, sum_ok, eok));
          ph = PH_IDLE;
        end
      endcase
      if (out.size() > 0) out[out.size() - 1].last = 1'b1;
      foreach (out[k]) pending_results.push_back(out[k]);
    endfunction

    function string fmt(result_t r);
      return $sformatf({"kind=%0d idx=%0d val=%0d pid=%0d tid=%0d route=%0d ",
                        "cok=%0d eok=%0d err=%0d last=%0d"},
                       r.kind, r.channel_index, r.channel_value, r.packet_id,
                       r.transmitter_id, r.route_len, r.checksum_ok, r.end_ok,
                       r.error_count, r.last);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        faults++;
        if (faults <= 10) $display("unexpected result: %s", fmt(got));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind || got.channel_index !== want.channel_index ||
          got.channel_value !== want.channel_value || got.packet_id !== want.packet_id ||
          got.transmitter_id !== want.transmitter_id ||
          got.route_len !== want.route_len ||
          got.checksum_ok !== want.checksum_ok || got.end_ok !== want.end_ok ||
          got.error_count !== want.error_count || got.last !== want.last) begin
        faults++;
        if (faults <= 10) begin
          $display("result mismatch");
          $display("  expected: %s", fmt(want));
          $display("  actual:   %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [7:0]  cfg_data  = '0;
  logic        rx_valid  = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte   = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        kind;
  logic [7:0]  channel_index;
  logic [11:0] channel_value;
  logic [7:0]  packet_id;
  logic [7:0]  transmitter_id;
  logic [3:0]  route_len;
  logic        checksum_ok;
  logic        end_ok;
  logic [7:0]  error_count;
  logic        last;

  result_t         seen;
  frame_scoreboard sb;
  bit              calm        = 1'b0;
  int unsigned     items_sent  = 0;
  int unsigned     quiet_cycles = 0;
  logic [7:0]      start_now   = START_MARKER_RESET;
  logic [7:0]      end_now     = END_MARKER_RESET;

  rc_frame_receiver_core dut (.*);

  assign seen = {kind, channel_index, channel_value, packet_id, transmitter_id,
                 route_len, checksum_ok, end_ok, error_count, last};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else res_stall <= !calm && ($urandom_range(99) < 18);
  end

  always @(posedge clk) begin
    if (!rst && rx_valid && !rx_stall) sb.note_byte(rx_byte);
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(seen);
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rc_frame_receiver_core_test NOT OK");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (rx_stall);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] pid, input logic [7:0] tid,
                            input logic [7:0] cfg, input logic [7:0] mesh,
                            input int fill, input bit bad_sum, input bit bad_end);
    logic [7:0] sum, d, e;
    int         n_bits, n_chans, len;
    n_bits  = 5 + cfg[2:0];
    n_chans = (cfg[5:3] == 3'd7) ? 256 : (1 << cfg[5:3]);
    len     = (n_bits * n_chans + 7) / 8;
    send_byte(start_now);
    send_byte(pid);
    send_byte(tid);
    send_byte(cfg);
    sum = pid ^ tid ^ cfg;
    if (cfg[7]) begin
      send_byte(mesh);
      sum ^= mesh;
    end
    repeat (len) begin
      d = (fill < 0) ? 8'($urandom) : fill[7:0];
      send_byte(d);
      sum ^= d;
    end
    if (bad_sum) sum ^= 8'($urandom_range(1, 255));
    send_byte(sum);
    e = end_now;
    if (bad_end) e ^= 8'($urandom_range(1, 255));
    send_byte(e);
  endtask

  task automatic random_frame(input bit force_max);
    logic [7:0] cfg;
    int         r, fill;
    cfg = 8'($urandom);
    r = $urandom_range(99);
    if (force_max) cfg[5:3] = 3'd7;
    else if (r < 85) cfg[5:3] = 3'($urandom_range(0, 3));
    else if (r < 98) cfg[5:3] = 3'($urandom_range(4, 5));
    else cfg[5:3] = 3'($urandom_range(6, 7));
    r = $urandom_range(99);
    fill = (r < 8) ? 0 : (r < 16) ? 255 : -1;
    send_frame(8'($urandom), 8'($urandom), cfg, 8'($urandom), fill,
               $urandom_range(99) < 30, $urandom_range(99) < 25);
  endtask

  task automatic run_phase(input int unsigned target);
    int r;
    while (items_sent < target) begin
      r = $urandom_range(99);
      if (r < 80) begin
        random_frame(1'b0);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        // start a frame and abandon it partway through its header
        send_byte(start_now);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end
    end
  endtask

  task automatic drain();
    rx_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
    cfg_valid <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_data  <= s;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_END_MARKER;
    cfg_data  <= e;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_markers(s, e);
    start_now = s;
    end_now   = e;
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h00, 8'hFF, 8'h40, 8'h00, 8'hC9, 1'b0, 1'b0);
    send_frame(8'hFF, 8'h00, 8'h8F, 8'hFF, 8'hFF, 1'b1, 1'b1);

    random_frame(1'b1);
    run_phase(500);
    drain();

    write_markers(8'h00, 8'hFF);
    run_phase(950);
    drain();

    write_markers(8'hFF, 8'h00);
    calm = 1'b1;
    run_phase(1250);
    calm = 1'b0;
    run_phase(1400);
    drain();

    write_markers(8'($urandom), 8'($urandom));
    run_phase(1850);
    drain();

    if (sb.faults == 0 && sb.pending_results.size() == 0)
      $display("rc_frame_receiver_core_test OK");
    else
      $display("rc_frame_receiver_core_test NOT OK");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/rcfr_pkg.sv
src/rc_frame_receiver_core.sv
tb/rc_frame_receiver_core_test.sv
